### hw/rtl/ltd_pkg.sv
// ----------------------------------------------------------------------------
// ltd_pkg
// shared widths, codes and defaults of the linear threshold diffusion engine
// ----------------------------------------------------------------------------
package ltd_pkg;

    // default sizes
    localparam int NODES_DEF     = 1024;
    localparam int EDGES_DEF     = 4096;
    localparam int FRAC_BITS_DEF = 16;

    // port field widths
    localparam int MODE_W   = 3;
    localparam int NODE_W   = 11;
    localparam int START_W  = 13;
    localparam int SLOT_W   = 12;
    localparam int TGT_W    = 10;
    localparam int WGT_W    = 17;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 11;
    localparam int SUM_W    = 24;
    localparam int CFG_W    = 24;

    // item modes
    localparam logic [MODE_W-1:0] MODE_ROW  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SEED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RUN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd2;

    // configuration register indexes
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_THRESHOLD  = 1'b1;

    // configuration reset values
    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 11'd1024;
    localparam logic [SUM_W-1:0]  THRESHOLD_RST  = 24'd32768;

endpackage

### hw/rtl/linear_threshold_diffusion_top.sv
// ----------------------------------------------------------------------------
// linear_threshold_diffusion_top
// threshold diffusion engine over a graph in compressed row form, run by one
// sequencer that walks frontier nodes and their edges one memory access at a time
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  cfg       in         cfg_we               cfg_index, cfg_data
//  in        in         in_valid / in_stall  mode, node_index, row_start,
//                                            edge_slot, edge_target, edge_weight
//  out       out        out_valid/out_stall  status, active_total,
//                                            deepest_level, node_level
//
//  after reset a clearing pass zeroes levels, sums and seed marks; in_stall is
//  high during it
//  a run first clears the level and sum of every node, then walks the seeds,
//  the frontier nodes and their edges; each ram has a single read port
//  one item is in work at a time; the result sits in an output register, so
//  the next item is taken while it waits and only blocks at its own result
// ----------------------------------------------------------------------------
module linear_threshold_diffusion_top #(
    parameter int NODES     = ltd_pkg::NODES_DEF,
    parameter int EDGES     = ltd_pkg::EDGES_DEF,
    parameter int FRAC_BITS = ltd_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ltd_pkg::CFG_W-1:0]     cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ltd_pkg::MODE_W-1:0]    mode,
    input  logic [ltd_pkg::NODE_W-1:0]    node_index,
    input  logic [ltd_pkg::START_W-1:0]   row_start,
    input  logic [ltd_pkg::SLOT_W-1:0]    edge_slot,
    input  logic [ltd_pkg::TGT_W-1:0]     edge_target,
    input  logic [ltd_pkg::WGT_W-1:0]     edge_weight,
    // results
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ltd_pkg::STATUS_W-1:0]  status,
    output logic [ltd_pkg::CNT_W-1:0]     active_total,
    output logic [ltd_pkg::CNT_W-1:0]     deepest_level,
    output logic [ltd_pkg::CNT_W-1:0]     node_level
);

    import ltd_pkg::*;

    // node address, counter (0..NODES), edge pointer (0..EDGES), row address
    localparam int NAW = $clog2(NODES);
    localparam int CW  = NAW + 1;
    localparam int EAW = $clog2(EDGES);
    localparam int EPW = EAW + 1;
    localparam int RAW = $clog2(NODES + 1);
    localparam int LW  = $clog2(NODES + 1);
    localparam int WW  = FRAC_BITS + 1;
    localparam int NDW = CW + SUM_W;
    localparam int EDW = NAW + WW;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_ADD, S_READ, S_RCLR, S_SRD, S_SGET, S_SCHK,
        S_FRD, S_FGET, S_ROW0, S_ROW1, S_ECHK, S_EGET, S_NUPD, S_LEND,
        S_FIN, S_DONE
    } state_t;

    state_t             state_reg;
    logic [NODE_W-1:0]  node_count_reg;
    logic [SUM_W-1:0]   thr_reg;

    logic [CW-1:0]      clr_reg;
    logic [CW-1:0]      seed_total_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      cur_reg;
    logic [CW-1:0]      nxt_reg;
    logic [CW-1:0]      total_reg;
    logic [CW-1:0]      deepest_reg;
    logic [CW-1:0]      lvl_reg;
    logic               sel_reg;
    logic [NAW-1:0]     node_reg;
    logic [NAW-1:0]     s_reg;
    logic [NAW-1:0]     u_reg;
    logic [NAW-1:0]     t_reg;
    logic [WW-1:0]      w_reg;
    logic [EPW-1:0]     e_reg;
    logic [EPW-1:0]     hi_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [CW-1:0]       res_level_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    total_out_reg;
    logic [CNT_W-1:0]    deepest_out_reg;
    logic [CNT_W-1:0]    level_out_reg;

    // ram ports
    logic               row_we;
    logic [RAW-1:0]     row_waddr;
    logic [EPW-1:0]     row_wdata;
    logic [RAW-1:0]     row_raddr;
    logic [EPW-1:0]     row_rdata;

    logic               edge_we;
    logic [EDW-1:0]     edge_rdata;

    logic               seed_we;
    logic [NAW-1:0]     seed_rdata;

    logic               mark_we;
    logic [NAW-1:0]     mark_waddr;
    logic               mark_wdata;
    logic               mark_rdata;

    logic               nd_we;
    logic [NAW-1:0]     nd_waddr;
    logic [NDW-1:0]     nd_wdata;
    logic [NAW-1:0]     nd_raddr;
    logic [NDW-1:0]     nd_rdata;

    logic               now_we;
    logic               next_we;
    logic [NAW-1:0]     front_wdata;
    logic [NAW-1:0]     front_waddr;
    logic               f0_we;
    logic               f1_we;
    logic [NAW-1:0]     f0_rdata;
    logic [NAW-1:0]     f1_rdata;
    logic [NAW-1:0]     now_rdata;

    // derived values
    logic [LW-1:0]      live;
    logic               acc;
    logic               out_free;
    logic               row_ok;
    logic               edge_ok;
    logic               node_ok;
    logic [CW-1:0]      nd_level;
    logic [SUM_W-1:0]   nd_sum;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic               hit;
    logic [NAW-1:0]     e_tgt;
    logic [WW-1:0]      e_wgt;
    logic [EPW-1:0]     row_cap;

    // effective node count: min(node_count, NODES)
    assign live = (32'(node_count_reg) < NODES) ? LW'(node_count_reg) : LW'(NODES);

    assign acc      = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    assign row_ok  = (32'(node_index) <= NODES) && (32'(row_start) <= EDGES);
    assign edge_ok = (32'(edge_slot) < EDGES) && (32'(edge_target) < NODES)
                     && (32'(edge_weight) <= (32'(1) << FRAC_BITS));
    assign node_ok = 32'(node_index) < 32'(live);

    assign nd_level = nd_rdata[NDW-1:SUM_W];
    assign nd_sum   = nd_rdata[SUM_W-1:0];
    assign e_tgt    = edge_rdata[EDW-1:WW];
    assign e_wgt    = edge_rdata[WW-1:0];
    assign now_rdata = sel_reg ? f1_rdata : f0_rdata;

    // saturating sum and threshold test of the edge being applied
    assign sum_wide = {1'b0, nd_sum} + (SUM_W + 1)'(w_reg);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign hit      = (sum_sat >= thr_reg);

    // end offset capped at EDGES
    assign row_cap = (32'(row_rdata) > EDGES) ? EPW'(EDGES) : row_rdata;

    // memory port control
    always_comb
    begin
        row_we    = acc && (mode == MODE_ROW) && row_ok;
        row_waddr = RAW'(node_index);
        row_wdata = EPW'(row_start);
        if (state_reg == S_FGET)
        begin
            row_raddr = RAW'(now_rdata);
        end
        else
        begin
            row_raddr = RAW'(u_reg) + RAW'(1);
        end

        edge_we = acc && (mode == MODE_EDGE) && edge_ok;
        seed_we = (state_reg == S_ADD) && !mark_rdata && (32'(seed_total_reg) < NODES);

        mark_we    = 1'b0;
        mark_waddr = node_reg;
        mark_wdata = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                mark_we    = 1'b1;
                mark_waddr = clr_reg[NAW-1:0];
            end
            S_ADD:
            begin
                mark_we    = seed_we;
                mark_wdata = 1'b1;
            end
            S_SGET:
            begin
                // seed marks clear as the run picks each seed up
                mark_we    = 1'b1;
                mark_waddr = seed_rdata;
            end
            default:
            begin
                mark_we = 1'b0;
            end
        endcase

        nd_we    = 1'b0;
        nd_waddr = clr_reg[NAW-1:0];
        nd_wdata = '0;
        now_we   = 1'b0;
        next_we  = 1'b0;
        front_waddr = cur_reg[NAW-1:0];
        front_wdata = s_reg;
        case (state_reg)
            S_CLR, S_RCLR:
            begin
                nd_we = 1'b1;
            end
            S_SCHK:
            begin
                if ((32'(s_reg) < 32'(live)) && (nd_level == '0))
                begin
                    nd_we    = 1'b1;
                    nd_waddr = s_reg;
                    nd_wdata = {CW'(1), {SUM_W{1'b0}}};
                    now_we   = 1'b1;
                end
            end
            S_NUPD:
            begin
                if (nd_level == '0)
                begin
                    nd_we    = 1'b1;
                    nd_waddr = t_reg;
                    nd_wdata = {(hit ? lvl_reg : CW'(0)), sum_sat};
                    next_we  = hit;
                    front_waddr = nxt_reg[NAW-1:0];
                    front_wdata = t_reg;
                end
            end
            default:
            begin
                nd_we = 1'b0;
            end
        endcase

        case (state_reg)
            S_SGET:  nd_raddr = seed_rdata;
            S_EGET:  nd_raddr = e_tgt;
            default: nd_raddr = NAW'(node_index);
        endcase

        // ping-pong frontier buffers
        f0_we = (now_we && !sel_reg) || (next_we && sel_reg);
        f1_we = (now_we && sel_reg) || (next_we && !sel_reg);
    end

    ltd_ram #(.WIDTH(EPW), .DEPTH(NODES + 1)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    ltd_ram #(.WIDTH(EDW), .DEPTH(EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (EAW'(edge_slot)),
        .wdata ({NAW'(edge_target), WW'(edge_weight)}),
        .raddr (e_reg[EAW-1:0]),
        .rdata (edge_rdata)
    );

    ltd_ram #(.WIDTH(NAW), .DEPTH(NODES)) u_seed_ram (
        .clk   (clk),
        .we    (seed_we),
        .waddr (seed_total_reg[NAW-1:0]),
        .wdata (node_reg),
        .raddr (i_reg[NAW-1:0]),
        .rdata (seed_rdata)
    );

    ltd_ram #(.WIDTH(1), .DEPTH(NODES)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (NAW'(node_index)),
        .rdata (mark_rdata)
    );

    // level and weight sum per node
    ltd_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node_ram (
        .clk   (clk),
        .we    (nd_we),
        .waddr (nd_waddr),
        .wdata (nd_wdata),
        .raddr (nd_raddr),
        .rdata (nd_rdata)
    );

    ltd_ram #(.WIDTH(NAW), .DEPTH(NODES)) u_front0_ram (
        .clk   (clk),
        .we    (f0_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .raddr (i_reg[NAW-1:0]),
        .rdata (f0_rdata)
    );

    ltd_ram #(.WIDTH(NAW), .DEPTH(NODES)) u_front1_ram (
        .clk   (clk),
        .we    (f1_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .raddr (i_reg[NAW-1:0]),
        .rdata (f1_rdata)
    );

    // sequencer, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            node_count_reg <= NODE_COUNT_RST;
            thr_reg        <= THRESHOLD_RST;
            clr_reg        <= '0;
            seed_total_reg <= '0;
            i_reg          <= '0;
            cur_reg        <= '0;
            nxt_reg        <= '0;
            total_reg      <= '0;
            deepest_reg    <= '0;
            lvl_reg        <= '0;
            sel_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_NODE_COUNT)
                begin
                    node_count_reg <= cfg_data[NODE_W-1:0];
                end
                else
                begin
                    thr_reg <= cfg_data[SUM_W-1:0];
                end
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (32'(clr_reg) == NODES - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        res_status_reg <= ST_OK;
                        res_level_reg  <= '0;
                        total_reg      <= '0;
                        deepest_reg    <= '0;
                        node_reg       <= NAW'(node_index);
                        state_reg      <= S_DONE;
                        case (mode)
                            MODE_ROW:
                            begin
                                if (!row_ok)
                                begin
                                    res_status_reg <= ST_RANGE;
                                end
                            end
                            MODE_EDGE:
                            begin
                                if (!edge_ok)
                                begin
                                    res_status_reg <= ST_RANGE;
                                end
                            end
                            MODE_SEED:
                            begin
                                if (!node_ok)
                                begin
                                    res_status_reg <= ST_RANGE;
                                end
                                else
                                begin
                                    state_reg <= S_ADD;
                                end
                            end
                            MODE_RUN:
                            begin
                                clr_reg   <= '0;
                                state_reg <= S_RCLR;
                            end
                            MODE_READ:
                            begin
                                if (!node_ok)
                                begin
                                    res_status_reg <= ST_RANGE;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                            default:
                            begin
                                res_status_reg <= ST_RANGE;
                            end
                        endcase
                    end
                end

                S_ADD:
                begin
                    if (mark_rdata)
                    begin
                        res_status_reg <= ST_DUP;
                    end
                    else if (seed_we)
                    begin
                        seed_total_reg <= seed_total_reg + CW'(1);
                    end
                    state_reg <= S_DONE;
                end

                S_READ:
                begin
                    res_level_reg <= nd_level;
                    state_reg     <= S_DONE;
                end

                S_RCLR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (32'(clr_reg) == NODES - 1)
                    begin
                        i_reg   <= '0;
                        cur_reg <= '0;
                        sel_reg <= 1'b0;
                        state_reg <= (seed_total_reg == '0) ? S_FIN : S_SRD;
                    end
                end

                S_SRD:
                begin
                    state_reg <= S_SGET;
                end

                S_SGET:
                begin
                    s_reg     <= seed_rdata;
                    state_reg <= S_SCHK;
                end

                S_SCHK:
                begin
                    if (now_we)
                    begin
                        cur_reg <= cur_reg + CW'(1);
                    end
                    i_reg <= i_reg + CW'(1);
                    if (i_reg + CW'(1) < seed_total_reg)
                    begin
                        state_reg <= S_SRD;
                    end
                    else
                    begin
                        state_reg <= S_LEND;
                        // seeds form level 1; the frontier walk starts from them
                        if (now_we || (cur_reg != '0))
                        begin
                            total_reg   <= cur_reg + CW'(now_we);
                            deepest_reg <= CW'(1);
                            lvl_reg     <= CW'(2);
                            nxt_reg     <= '0;
                            i_reg       <= '0;
                            cur_reg     <= cur_reg + CW'(now_we);
                            state_reg   <= S_FRD;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end

                S_FRD:
                begin
                    state_reg <= S_FGET;
                end

                S_FGET:
                begin
                    u_reg     <= now_rdata;
                    state_reg <= S_ROW0;
                end

                S_ROW0:
                begin
                    e_reg     <= row_rdata;
                    state_reg <= S_ROW1;
                end

                S_ROW1:
                begin
                    hi_reg    <= row_cap;
                    state_reg <= S_ECHK;
                end

                S_ECHK:
                begin
                    if (e_reg < hi_reg)
                    begin
                        state_reg <= S_EGET;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= (i_reg + CW'(1) < cur_reg) ? S_FRD : S_LEND;
                    end
                end

                S_EGET:
                begin
                    t_reg <= e_tgt;
                    w_reg <= e_wgt;
                    if (32'(e_tgt) < 32'(live))
                    begin
                        state_reg <= S_NUPD;
                    end
                    else
                    begin
                        e_reg     <= e_reg + EPW'(1);
                        state_reg <= S_ECHK;
                    end
                end

                S_NUPD:
                begin
                    if (next_we)
                    begin
                        nxt_reg <= nxt_reg + CW'(1);
                    end
                    e_reg     <= e_reg + EPW'(1);
                    state_reg <= S_ECHK;
                end

                S_LEND:
                begin
                    if (nxt_reg == '0)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        sel_reg     <= !sel_reg;
                        cur_reg     <= nxt_reg;
                        total_reg   <= total_reg + nxt_reg;
                        deepest_reg <= lvl_reg;
                        lvl_reg     <= lvl_reg + CW'(1);
                        nxt_reg     <= '0;
                        i_reg       <= '0;
                        state_reg   <= S_FRD;
                    end
                end

                S_FIN:
                begin
                    seed_total_reg <= '0;
                    state_reg      <= S_DONE;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= res_status_reg;
                        total_out_reg   <= CNT_W'(total_reg);
                        deepest_out_reg <= CNT_W'(deepest_reg);
                        level_out_reg   <= CNT_W'(res_level_reg);
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign active_total  = total_out_reg;
    assign deepest_level = deepest_out_reg;
    assign node_level    = level_out_reg;

endmodule

### hw/rtl/ltd_ram.sv
// ----------------------------------------------------------------------------
// ltd_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ltd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/ltd_checker.sv
// ----------------------------------------------------------------------------
// ltd_checker
// port level checks of the diffusion engine, bound to the top level
// ----------------------------------------------------------------------------
module ltd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [ltd_pkg::STATUS_W-1:0]  status,
    input logic [ltd_pkg::CNT_W-1:0]     active_total,
    input logic [ltd_pkg::CNT_W-1:0]     deepest_level,
    input logic [ltd_pkg::CNT_W-1:0]     node_level
);

    import ltd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // the block is busy in the cycle after every accepted transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a transfer");

    // a rejected item reports no run figures and no level
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |->
            active_total == '0 && deepest_level == '0 && node_level == '0)
        else $error("rejected item carries data");

    // an empty run has no deepest level
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && active_total == '0 |-> deepest_level == '0)
        else $error("deepest level without active nodes");

    // run figures and read levels never come together
    a_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && node_level != '0 |-> active_total == '0)
        else $error("read level mixed with run figures");

endmodule

bind linear_threshold_diffusion_top ltd_checker u_ltd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .active_total  (active_total),
    .deepest_level (deepest_level),
    .node_level    (node_level)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the linear threshold diffusion engine: builds small
// graphs in compressed row form, seeds and runs them under several node counts
// and thresholds, mixes in malformed loads and reads, and checks every result
// transfer against an in-bench model of the graph, seeds and levels
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ltd_pkg::*;

    localparam int NODE_CAP = 1024;
    localparam int SLOT_CAP = 4096;
    localparam int WEIGHT_ONE = 65536;
    localparam int SUM_SAT = 24'hFFFFFF;
    localparam int HOLD_CYCLES = 400;
    localparam int GRAPH_MAX = 64;
    localparam int ROUNDS = 32;
    // codes above MODE_READ are undefined and must answer a range error
    localparam logic [MODE_W-1:0] MODE_UNDEF_LO = MODE_READ + 3'd1;
    localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [NODE_W-1:0]  node;
        logic [START_W-1:0] start;
        logic [SLOT_W-1:0]  slot;
        logic [TGT_W-1:0]   target;
        logic [WGT_W-1:0]   weight;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    total;
        logic [CNT_W-1:0]    deepest;
        logic [CNT_W-1:0]    level;
    } answer_t;

    // ------------------------------------------------------------------------
    // graph model and queue of expected answers
    // ------------------------------------------------------------------------
    class diffusion_scoreboard;
        int      offs[NODE_CAP+1];
        bit      offs_set[NODE_CAP+1];
        int      tgt[SLOT_CAP];
        int      wgt[SLOT_CAP];
        bit      slot_set[SLOT_CAP];
        bit      marked[NODE_CAP];
        int      seeds[$];
        int      lvl[NODE_CAP];
        int      node_count = NODE_COUNT_RST;
        int      thr = THRESHOLD_RST;
        answer_t pending[$];
        int      errors = 0;

        function int live();
            return (node_count < NODE_CAP) ? node_count : NODE_CAP;
        endfunction

        function void set_reg(logic idx, int value);
            if (idx == CFG_NODE_COUNT)
                node_count = value & 'h7FF;
            else
                thr = value & SUM_SAT;
        endfunction

        // a run may only touch offsets and edge slots that were loaded
        function bit run_safe();
            int n, lo, hi;
            n = live();
            for (int u = 0; u < n; u++) begin
                if (!offs_set[u] || !offs_set[u+1])
                    return 0;
                lo = offs[u];
                hi = (offs[u+1] > SLOT_CAP) ? SLOT_CAP : offs[u+1];
                for (int e = lo; e < hi; e++)
                    if (!slot_set[e])
                        return 0;
            end
            return 1;
        endfunction

        function void diffuse(ref answer_t r);
            int n, lo, hi, t, sum, total, deepest, depth;
            int sums[NODE_CAP];
            int cur[$];
            int nxt[$];
            n = live();
            total = 0;
            deepest = 0;
            depth = 2;
            foreach (lvl[i]) lvl[i] = 0;
            foreach (sums[i]) sums[i] = 0;
            foreach (seeds[i])
                if (seeds[i] < n && lvl[seeds[i]] == 0) begin
                    lvl[seeds[i]] = 1;
                    cur.push_back(seeds[i]);
                end
            total = cur.size();
            if (total > 0)
                deepest = 1;
            while (cur.size() > 0) begin
                nxt.delete();
                foreach (cur[k]) begin
                    lo = offs[cur[k]];
                    hi = (offs[cur[k]+1] > SLOT_CAP) ? SLOT_CAP : offs[cur[k]+1];
                    for (int e = lo; e < hi; e++) begin
                        t = tgt[e];
                        if (t >= n || lvl[t] != 0)
                            continue;
                        sum = sums[t] + wgt[e];
                        if (sum > SUM_SAT)
                            sum = SUM_SAT;
                        sums[t] = sum;
                        if (sum >= thr) begin
                            lvl[t] = depth;
                            nxt.push_back(t);
                        end
                    end
                end
                if (nxt.size() == 0)
                    break;
                cur = nxt;
                total += nxt.size();
                deepest = depth;
                depth++;
            end
            foreach (marked[i]) marked[i] = 0;
            seeds.delete();
            r.total = total;
            r.deepest = deepest;
        endfunction

        function void note_input(cmd_t c);
            answer_t r;
            r = '0;
            case (c.mode)
                MODE_ROW:
                    if (c.node > NODE_CAP || c.start > SLOT_CAP)
                        r.status = ST_RANGE;
                    else begin
                        offs[c.node] = c.start;
                        offs_set[c.node] = 1;
                    end
                MODE_EDGE:
                    if (c.weight > WEIGHT_ONE)
                        r.status = ST_RANGE;
                    else begin
                        tgt[c.slot] = c.target;
                        wgt[c.slot] = c.weight;
                        slot_set[c.slot] = 1;
                    end
                MODE_SEED:
                    if (c.node >= live())
                        r.status = ST_RANGE;
                    else if (marked[c.node])
                        r.status = ST_DUP;
                    else begin
                        marked[c.node] = 1;
                        seeds.push_back(c.node);
                    end
                MODE_RUN:
                    diffuse(r);
                MODE_READ:
                    if (c.node >= live())
                        r.status = ST_RANGE;
                    else
                        r.level = lvl[c.node];
                default:
                    r.status = ST_RANGE;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(answer_t got);
            answer_t want;
            if (pending.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.total !== want.total) begin
                $error("active_total: expected %0d, got %0d", want.total, got.total);
                errors++;
            end
            if (got.deepest !== want.deepest) begin
                $error("deepest_level: expected %0d, got %0d", want.deepest, got.deepest);
                errors++;
            end
            if (got.level !== want.level) begin
                $error("node_level: expected %0d, got %0d", want.level, got.level);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and the block
    // ------------------------------------------------------------------------
    logic                clk = 0;
    logic                rst_n = 0;
    logic                cfg_we = 0;
    logic                cfg_index = 0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 0;
    logic                in_stall;
    logic [MODE_W-1:0]   mode = '0;
    logic [NODE_W-1:0]   node_index = '0;
    logic [START_W-1:0]  row_start = '0;
    logic [SLOT_W-1:0]   edge_slot = '0;
    logic [TGT_W-1:0]    edge_target = '0;
    logic [WGT_W-1:0]    edge_weight = '0;
    logic                out_valid;
    logic                out_stall = 0;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    active_total;
    logic [CNT_W-1:0]    deepest_level;
    logic [CNT_W-1:0]    node_level;

    diffusion_scoreboard sb = new();
    bit idle_on = 1;      // random gaps on both sides when set
    bit hold_req = 0;     // receiver holds off for a long stretch

    always #1 clk = ~clk;

    linear_threshold_diffusion_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .node_index    (node_index),
        .row_start     (row_start),
        .edge_slot     (edge_slot),
        .edge_target   (edge_target),
        .edge_weight   (edge_weight),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .active_total  (active_total),
        .deepest_level (deepest_level),
        .node_level    (node_level)
    );

    // mostly short gaps, now and then a long one
    function int gap_len();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall, long hold-off on request, check each transfer
    // ------------------------------------------------------------------------
    initial begin
        int g;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall = 1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
                out_stall = 0;
            end
            else begin
                g = gap_len();
                if (g > 0) begin
                    out_stall = 1;
                    repeat (g - 1) @(negedge clk);
                    // release takes effect at the next negedge
                    @(negedge clk);
                    out_stall = 0;
                end
            end
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{status, active_total, deepest_level, node_level});

    // ------------------------------------------------------------------------
    // drive tasks
    // ------------------------------------------------------------------------
    // one input transfer, then an optional gap; valid stays high when the
    // next item follows with no gap
    task automatic send(cmd_t c);
        int g;
        @(negedge clk);
        in_valid = 1;
        mode = c.mode;
        node_index = c.node;
        row_start = c.start;
        edge_slot = c.slot;
        edge_target = c.target;
        edge_weight = c.weight;
        do @(posedge clk); while (in_stall);
        sb.note_input(c);
        g = gap_len();
        if (g > 0) begin
            @(negedge clk);
            in_valid = 0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic send_op(logic [MODE_W-1:0] m, int nd, int st = 0, int sl = 0,
                           int tg = 0, int wt = 0);
        cmd_t c;
        c.mode = m;
        c.node = nd;
        c.start = st;
        c.slot = sl;
        c.target = tg;
        c.weight = wt;
        send(c);
    endtask

    // wait until every expected result has arrived and the block is quiet
    task automatic drain();
        @(negedge clk);
        in_valid = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = value;
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_we = 0;
    endtask

    // compressed rows for nodes 0..n; only the first `busy` nodes get edges
    task automatic build_graph(int n, int busy);
        int pos, deg;
        int w;
        pos = 0;
        for (int u = 0; u <= n; u++) begin
            send_op(MODE_ROW, u, pos);
            deg = (u < busy) ? $urandom_range(0, 4) : 0;
            if (u < n)
                pos += deg;
        end
        for (int e = 0; e < pos; e++) begin
            case ($urandom_range(0, 5))
                0: w = WEIGHT_ONE;
                1: w = 0;
                default: w = $urandom_range(1, WEIGHT_ONE);
            endcase
            // a few targets beyond the live node count act as stale edges
            send_op(MODE_EDGE, 0, 0, e,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, (n > 0) ? n - 1 : 0),
                    w);
        end
    endtask

    // anything at all, made harmless where it would break the loaded graph
    task automatic send_noise();
        cmd_t c;
        c = cmd_t'(CMD_W'({$urandom, $urandom, $urandom}));
        c.mode = $urandom_range(0, 7);
        if (c.mode == MODE_RUN && !sb.run_safe())
            c.mode = $urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI);
        if (c.mode == MODE_ROW && c.node <= NODE_CAP && c.start <= SLOT_CAP)
            c.start = $urandom_range(SLOT_CAP + 1, 8191);
        send(c);
    endtask

    task automatic send_random(int n);
        int r, k;
        r = $urandom_range(0, 99);
        if (r < 30)
            send_op(MODE_SEED, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                           : $urandom_range(0, n));
        else if (r < 48)
            send_op(MODE_READ, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                           : $urandom_range(0, n));
        else if (r < 54 && sb.run_safe())
            send_op(MODE_RUN, 0);
        else if (r < 66)
            send_op(MODE_EDGE, 0, 0, $urandom_range(0, SLOT_CAP - 1),
                    $urandom_range(0, 1023), $urandom_range(0, WEIGHT_ONE));
        else if (r < 78)
            send_noise();
        else begin
            // well-formed: seeds, a run, then reads of the outcome
            k = $urandom_range(1, 4);
            repeat (k)
                send_op(MODE_SEED, $urandom_range(0, (n > 0) ? n - 1 : 0));
            if (sb.run_safe())
                send_op(MODE_RUN, 0);
            k = $urandom_range(2, 5);
            repeat (k)
                send_op(MODE_READ, $urandom_range(0, (n > 0) ? n - 1 : 0));
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    int phase_nodes[8] = '{8, 0, 16, 2047, 30, 12, 1, 24};
    int phase_thr[8]   = '{32768, 100, 0, 65536, 24'hFFFFFF, 40000, 65536, 70000};

    initial begin
        int n;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_NODE_COUNT, phase_nodes[p]);
            write_reg(CFG_THRESHOLD, phase_thr[p]);
            n = sb.live();
            idle_on = (p != 2);
            // the full-size phase loads no graph and so never runs; it checks
            // the node count clamp on seeds and reads
            if (n <= GRAPH_MAX)
                build_graph(n, n);

            if (p == 0) begin
                // range errors on every kind of load, undefined modes
                send_op(MODE_ROW, 1025, 0);
                send_op(MODE_ROW, 2047, 8191);
                send_op(MODE_ROW, 3, SLOT_CAP + 1);
                send_op(MODE_EDGE, 0, 0, 4095, 1023, WEIGHT_ONE + 1);
                send_op(MODE_EDGE, 0, 0, 4095, 1023, 131071);
                send_op(MODE_UNDEF_LO, 0);
                send_op(MODE_UNDEF_LO + 3'd1, 0);
                send_op(MODE_UNDEF_HI, 2047, 8191, 4095, 1023, 131071);
                // seeds: good, duplicate, out of range
                send_op(MODE_SEED, 0);
                send_op(MODE_SEED, 0);
                send_op(MODE_SEED, 7);
                send_op(MODE_SEED, 8);
                send_op(MODE_SEED, 2047);
                send_op(MODE_READ, 8);
                send_op(MODE_RUN, 0);
                for (int i = 0; i < 8; i++)
                    send_op(MODE_READ, i);
                // seeds left over for the next phase become stale there
                send_op(MODE_SEED, 5);
                send_op(MODE_SEED, 3);
            end
            if (p == 1) begin
                // empty graph: the stale seeds are skipped
                send_op(MODE_RUN, 0);
                send_op(MODE_READ, 0);
            end

            for (int i = 0; i < ROUNDS; i++) begin
                send_random(n);
                if (i == 12 && p == 2) begin
                    // receiver holds off while the sender keeps offering
                    hold_req = 1;
                    repeat (12) send_random(n);
                    while (hold_req)
                        @(posedge clk);
                end
                if (i == 20 && p == 4)
                    drain();
            end
            // seeds are not cleared here on purpose
            drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // overall time limit
    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

endmodule
